// ===== rtl/core/titration_pump_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the titration pump sequencer
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TITRATION_PUMP_SEQUENCER_DEFINES_SVH
`define TITRATION_PUMP_SEQUENCER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// Titration pump sequencer package
// Phase, function, pump, error and register codes plus the config and state records.
// ----------------------------------------------------------------------------
`default_nettype none
package tps_pkg;

  localparam int TimeBits = 32;
  localparam int CfgBits  = 20;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CLEAN = 3'd1,
    PH_REF   = 3'd2,
    PH_MEAS  = 3'd3,
    PH_FIN   = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6,
    PH_RSVD  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    FN_STEP  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  localparam logic [1:0] P_OFF  = 2'd0;
  localparam logic [1:0] P_FILL = 2'd1;
  localparam logic [1:0] P_DIS  = 2'd2;

  localparam logic [3:0] E_NONE    = 4'd0;
  localparam logic [3:0] E_UNCFG   = 4'd1;
  localparam logic [3:0] E_BUSY    = 4'd2;
  localparam logic [3:0] E_CLN_A   = 4'd3;
  localparam logic [3:0] E_RELIEF  = 4'd4;
  localparam logic [3:0] E_REF_B   = 4'd5;
  localparam logic [3:0] E_REF_A   = 4'd6;
  localparam logic [3:0] E_REF_C   = 4'd7;
  localparam logic [3:0] E_MEAS_B  = 4'd8;
  localparam logic [3:0] E_KH      = 4'd9;
  localparam logic [3:0] E_DELTA   = 4'd10;

  localparam logic [2:0] REG_REF_SET     = 3'd0;
  localparam logic [2:0] REG_DRAIN       = 3'd1;
  localparam logic [2:0] REG_TRANSFER    = 3'd2;
  localparam logic [2:0] REG_FILL        = 3'd3;
  localparam logic [2:0] REG_REF_AIR     = 3'd4;
  localparam logic [2:0] REG_SAMPLE_FILL = 3'd5;
  localparam logic [2:0] REG_SAMPLE_AIR  = 3'd6;
  localparam logic [2:0] REG_RELIEF      = 3'd7;

  typedef struct packed {
    logic                 reference_set;
    logic [CfgBits-1:0]   drain;
    logic [CfgBits-1:0]   transfer;
    logic [CfgBits-1:0]   fill;
    logic [CfgBits-1:0]   ref_air;
    logic [CfgBits-1:0]   sample_fill;
    logic [CfgBits-1:0]   sample_air;
    logic [CfgBits-1:0]   relief;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [2:0]           sub;
    logic                 started;
    logic [TimeBits-1:0]  t0;
    logic                 relief;
    logic [TimeBits-1:0]  rt0;
    logic [1:0]           pa;
    logic [1:0]           pb;
    logic [1:0]           pc;
    logic                 air;
    logic [10:0]          ph_ref;
    logic [10:0]          ph_smp;
    logic signed [14:0]   temp;
    logic [10:0]          kh;
    logic                 valid;
    logic [3:0]           err;
  } seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/titration_pump_sequencer.sv =====
// ----------------------------------------------------------------------------
// Titration pump sequencer
// Event-driven clean, reference, measure and finalize pump sequencer.
// ----------------------------------------------------------------------------
// Usage: write configuration on cfg_valid/cfg_ready (always ready), index
// 0..7 selects the register, cfg_data[19:0] is the value (bit 0 for
// reference_set). Configure only while no event item is outstanding.
// Events (func, now_ms, reservoir flags, pH and temperature) enter on
// in_valid/in_ready. Each accepted event yields exactly one result item on
// out_valid/out_ready carrying pump drives, phase, advance flag, error code
// and the stored measurement.
// out_valid rises in the cycle after acceptance. Throughput is one item
// per cycle: the state register is updated when the item is accepted and the
// result is held in an output register; in_ready stays high while that
// register is empty or being drained in the same cycle.
// If the receiver stalls, the result holds and in_ready drops until it is
// taken. Reset clears the sequencer to idle with all pumps off, loads the
// default timing registers and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "titration_pump_sequencer_defines.svh"
module titration_pump_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [31:0]        now_ms,
  input  wire logic               a_full,
  input  wire logic               b_full,
  input  wire logic               a_can_receive,
  input  wire logic               b_can_receive,
  input  wire logic               c_can_receive,
  input  wire logic [10:0]        ph_reading,
  input  wire logic signed [14:0] temp_reading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              pump_a_drive,
  output logic [1:0]              pump_b_drive,
  output logic [1:0]              pump_c_drive,
  output logic                    air_pump_on,
  output logic [2:0]              phase,
  output logic                    phase_advanced,
  output logic [3:0]              error_code,
  output logic [10:0]             alkalinity,
  output logic                    result_valid,
  output logic [10:0]             ph_ref_out,
  output logic [10:0]             ph_sample_out,
  output logic signed [14:0]      temperature_out
);

  tps_pkg::cfg_t       cfg;
  tps_pkg::seq_state_t st;
  tps_pkg::seq_state_t st_next;
  logic                adv;
  logic                take;

  tps_cfg_regs u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  tps_step_logic u_step (
    .cur(st), .cfg, .func, .now_ms, .a_full, .b_full, .a_can_receive,
    .b_can_receive, .c_can_receive, .ph_reading, .temp_reading,
    .nxt(st_next), .adv
  );

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Advance the sequencer state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase   <= tps_pkg::PH_IDLE;
      st.sub     <= 3'd0;
      st.started <= 1'b0;
      st.t0      <= '0;
      st.relief  <= 1'b0;
      st.rt0     <= '0;
      st.pa      <= tps_pkg::P_OFF;
      st.pb      <= tps_pkg::P_OFF;
      st.pc      <= tps_pkg::P_OFF;
      st.air     <= 1'b0;
      st.ph_ref  <= 11'd0;
      st.ph_smp  <= 11'd0;
      st.temp    <= 15'sd2500;
      st.kh      <= 11'd0;
      st.valid   <= 1'b0;
      st.err     <= tps_pkg::E_NONE;
    end else if (take) begin
      st <= st_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pump_a_drive    <= st_next.pa;
      pump_b_drive    <= st_next.pb;
      pump_c_drive    <= st_next.pc;
      air_pump_on     <= st_next.air;
      phase           <= st_next.phase;
      phase_advanced  <= adv;
      error_code      <= st_next.err;
      alkalinity      <= st_next.kh;
      result_valid    <= st_next.valid;
      ph_ref_out      <= st_next.ph_ref;
      ph_sample_out   <= st_next.ph_smp;
      temperature_out <= st_next.temp;
    end
  end

  `TPS_ASSERT_NEXT(a_stop_idle, take && func == tps_pkg::FN_STOP,
    st.phase == tps_pkg::PH_IDLE && st.pa == tps_pkg::P_OFF && !st.relief,
    "stop did not return to idle with pumps off")
  `TPS_ASSERT_NEXT(a_out_match, take, phase == st.phase && error_code == st.err,
    "result register disagrees with sequencer state")
  // An unconfigured start may park the block in error with relief still set
  `TPS_ASSERT_IMP(a_relief_clean, st.relief,
    (st.phase == tps_pkg::PH_CLEAN && st.sub == 3'd2) || st.phase == tps_pkg::PH_ERR,
    "relief active outside the transfer sub-step")
  `TPS_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(phase),
    "stalled result changed")

endmodule
`default_nettype wire

// ===== rtl/core/tps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the reference flag and the seven timing registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output tps_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  // Write one register per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference_set <= 1'b0;
      cfg.drain         <= 20'd30000;
      cfg.transfer      <= 20'd30000;
      cfg.fill          <= 20'd30000;
      cfg.ref_air       <= 20'd30000;
      cfg.sample_fill   <= 20'd30000;
      cfg.sample_air    <= 20'd30000;
      cfg.relief        <= 20'd3000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tps_pkg::REG_REF_SET:     cfg.reference_set <= cfg_data[0];
        tps_pkg::REG_DRAIN:       cfg.drain         <= cfg_data[19:0];
        tps_pkg::REG_TRANSFER:    cfg.transfer      <= cfg_data[19:0];
        tps_pkg::REG_FILL:        cfg.fill          <= cfg_data[19:0];
        tps_pkg::REG_REF_AIR:     cfg.ref_air       <= cfg_data[19:0];
        tps_pkg::REG_SAMPLE_FILL: cfg.sample_fill   <= cfg_data[19:0];
        tps_pkg::REG_SAMPLE_AIR:  cfg.sample_air    <= cfg_data[19:0];
        tps_pkg::REG_RELIEF:      cfg.relief        <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tps_step_logic.sv =====
// ----------------------------------------------------------------------------
// Sequencer next-state logic
// Combinational update of the sequencer state for one event item.
// ----------------------------------------------------------------------------
`default_nettype none
module tps_step_logic (
  input  wire tps_pkg::seq_state_t  cur,
  input  wire tps_pkg::cfg_t        cfg,
  input  wire logic [1:0]           func,
  input  wire logic [31:0]          now_ms,
  input  wire logic                 a_full,
  input  wire logic                 b_full,
  input  wire logic                 a_can_receive,
  input  wire logic                 b_can_receive,
  input  wire logic                 c_can_receive,
  input  wire logic [10:0]          ph_reading,
  input  wire logic signed [14:0]   temp_reading,
  output tps_pkg::seq_state_t       nxt,
  output logic                      adv
);

  logic [31:0]        el;
  logic [31:0]        rel;
  logic               ca;
  logic               aa;
  logic               ba;
  logic signed [12:0] d;
  logic [11:0]        ad;
  logic signed [18:0] k;
  logic [10:0]        kc;
  logic               kbad;

  assign el  = now_ms - cur.t0;
  assign rel = now_ms - cur.rt0;

  // KH from stored reference and the fresh sample reading
  always_comb begin
    d  = $signed({2'b00, cur.ph_ref}) - $signed({2'b00, ph_reading});
    ad = d[12] ? 12'(-d) : 12'(d);
    k  = 19'(d) * 19'sd50;
    if (cur.ph_ref == 11'd0 || ph_reading == 11'd0) begin
      kc   = 11'd0;
      kbad = 1'b1;
    end else if (k < 19'sd100) begin
      kc   = 11'd100;
      kbad = 1'b0;
    end else if (k > 19'sd2000) begin
      kc   = 11'd2000;
      kbad = 1'b0;
    end else begin
      kc   = 11'(k);
      kbad = 1'b0;
    end
  end

  // Step the phase and sub-step sequencer
  always_comb begin
    nxt = cur;
    adv = 1'b0;
    ca  = 1'b0;
    aa  = 1'b0;
    ba  = 1'b0;
    case (func)
      tps_pkg::FN_START: begin
        if (!cfg.reference_set) begin
          nxt.err   = tps_pkg::E_UNCFG;
          nxt.phase = tps_pkg::PH_ERR;
        end else if (cur.phase != tps_pkg::PH_IDLE) begin
          nxt.err = tps_pkg::E_BUSY;
        end else begin
          nxt.phase = tps_pkg::PH_CLEAN;
          adv       = 1'b1;
        end
      end
      tps_pkg::FN_STOP: begin
        nxt.pa = tps_pkg::P_OFF;  nxt.pb = tps_pkg::P_OFF;
        nxt.pc = tps_pkg::P_OFF;  nxt.air = 1'b0;
        nxt.phase = tps_pkg::PH_IDLE;
        nxt.sub = 3'd0;  nxt.started = 1'b0;  nxt.relief = 1'b0;
      end
      tps_pkg::FN_STEP: begin
        case (cur.phase)
          tps_pkg::PH_CLEAN: begin
            case (cur.sub)
              3'd0: begin nxt.sub = 3'd1; nxt.started = 1'b0; end
              3'd1, 3'd3: begin
                if (!cur.started) begin
                  nxt.pa = tps_pkg::P_DIS; nxt.started = 1'b1; nxt.t0 = now_ms;
                end else if (el >= 32'(cfg.drain)) begin
                  nxt.pa = tps_pkg::P_OFF; nxt.sub = cur.sub + 3'd1;
                  nxt.started = 1'b0;
                end
              end
              3'd2: begin
                if (!cur.started) begin
                  if (!a_can_receive) begin
                    nxt.pa = tps_pkg::P_OFF; nxt.pb = tps_pkg::P_OFF;
                    nxt.err = tps_pkg::E_CLN_A; nxt.phase = tps_pkg::PH_ERR;
                    nxt.sub = 3'd0; nxt.started = 1'b0; nxt.relief = 1'b0;
                  end else begin
                    nxt.pa = tps_pkg::P_DIS; nxt.pb = tps_pkg::P_DIS;
                    nxt.started = 1'b1; nxt.t0 = now_ms;
                  end
                end else if (cur.relief || a_full) begin
                  if (!cur.relief) begin
                    nxt.pb = tps_pkg::P_OFF; nxt.relief = 1'b1; nxt.rt0 = now_ms;
                  end
                  if (a_full) begin
                    if ((cur.relief ? rel : 32'd0) >= 32'(cfg.relief)) begin
                      nxt.pa = tps_pkg::P_OFF; nxt.err = tps_pkg::E_RELIEF;
                      nxt.phase = tps_pkg::PH_ERR; nxt.sub = 3'd0;
                      nxt.started = 1'b0; nxt.relief = 1'b0;
                    end
                  end else begin
                    nxt.relief = 1'b0; nxt.pb = tps_pkg::P_DIS;
                    if (el >= 32'(cfg.transfer)) begin
                      nxt.pb = tps_pkg::P_OFF; nxt.sub = 3'd3; nxt.started = 1'b0;
                    end
                  end
                end else if (el >= 32'(cfg.transfer)) begin
                  nxt.pb = tps_pkg::P_OFF; nxt.sub = 3'd3; nxt.started = 1'b0;
                end
              end
              3'd4: begin
                nxt.pa = tps_pkg::P_OFF; nxt.pb = tps_pkg::P_OFF;
                nxt.sub = 3'd0; nxt.started = 1'b0;
                nxt.phase = tps_pkg::PH_REF; adv = 1'b1;
              end
              default: begin nxt.sub = 3'd0; nxt.started = 1'b0; end
            endcase
          end
          tps_pkg::PH_REF: begin
            case (cur.sub)
              3'd0: begin nxt.sub = 3'd1; nxt.started = 1'b0; end
              3'd1: begin
                if (!cur.started) begin
                  if (!b_can_receive || !a_can_receive) begin
                    nxt.pc = tps_pkg::P_OFF; nxt.pa = tps_pkg::P_OFF;
                    nxt.err = !b_can_receive ? tps_pkg::E_REF_B : tps_pkg::E_REF_A;
                    nxt.phase = tps_pkg::PH_ERR; nxt.sub = 3'd0;
                    nxt.started = 1'b0; nxt.relief = 1'b0;
                  end else begin
                    nxt.pc = tps_pkg::P_DIS; nxt.pa = tps_pkg::P_FILL;
                    nxt.started = 1'b1; nxt.t0 = now_ms;
                  end
                end else begin
                  ca = cur.pc != tps_pkg::P_OFF;
                  aa = cur.pa != tps_pkg::P_OFF;
                  if (ca && b_full) begin nxt.pc = tps_pkg::P_OFF; ca = 1'b0; end
                  if (aa && a_full) begin nxt.pa = tps_pkg::P_OFF; aa = 1'b0; end
                  if (el >= 32'(cfg.fill) && (ca || aa)) begin
                    nxt.pc = tps_pkg::P_OFF; nxt.pa = tps_pkg::P_OFF;
                    ca = 1'b0; aa = 1'b0;
                  end
                  if (!ca && !aa) begin nxt.sub = 3'd2; nxt.started = 1'b0; end
                end
              end
              3'd2: begin
                if (!cur.started) begin
                  nxt.air = 1'b1; nxt.started = 1'b1; nxt.t0 = now_ms;
                end else if (el >= 32'(cfg.ref_air)) begin
                  nxt.air = 1'b0; nxt.ph_ref = ph_reading; nxt.temp = temp_reading;
                  nxt.sub = 3'd3; nxt.started = 1'b0;
                end
              end
              3'd3: begin
                if (!cur.started) begin
                  if (!c_can_receive) begin
                    nxt.pc = tps_pkg::P_OFF; nxt.err = tps_pkg::E_REF_C;
                    nxt.phase = tps_pkg::PH_ERR; nxt.sub = 3'd0;
                    nxt.started = 1'b0; nxt.relief = 1'b0;
                  end else begin
                    nxt.pc = tps_pkg::P_FILL; nxt.started = 1'b1; nxt.t0 = now_ms;
                  end
                end else if (el >= 32'(cfg.fill)) begin
                  nxt.pc = tps_pkg::P_OFF; nxt.sub = 3'd4; nxt.started = 1'b0;
                end
              end
              3'd4: begin
                nxt.pa = tps_pkg::P_OFF; nxt.pc = tps_pkg::P_OFF; nxt.air = 1'b0;
                nxt.sub = 3'd0; nxt.started = 1'b0;
                nxt.phase = tps_pkg::PH_MEAS; adv = 1'b1;
              end
              default: begin nxt.sub = 3'd0; nxt.started = 1'b0; end
            endcase
          end
          tps_pkg::PH_MEAS: begin
            case (cur.sub)
              3'd0: begin nxt.sub = 3'd1; nxt.started = 1'b0; end
              3'd1: begin
                if (!cur.started) begin
                  if (!b_can_receive) begin
                    nxt.pb = tps_pkg::P_OFF; nxt.err = tps_pkg::E_MEAS_B;
                    nxt.phase = tps_pkg::PH_ERR; nxt.sub = 3'd0;
                    nxt.started = 1'b0; nxt.relief = 1'b0;
                  end else begin
                    nxt.pb = tps_pkg::P_FILL; nxt.started = 1'b1; nxt.t0 = now_ms;
                  end
                end else begin
                  ba = cur.pb != tps_pkg::P_OFF;
                  if (ba && (b_full || el >= 32'(cfg.sample_fill))) begin
                    nxt.pb = tps_pkg::P_OFF; ba = 1'b0;
                  end
                  if (!ba) begin nxt.sub = 3'd2; nxt.started = 1'b0; end
                end
              end
              3'd2: begin
                if (!cur.started) begin
                  nxt.air = 1'b1; nxt.started = 1'b1; nxt.t0 = now_ms;
                end else if (el >= 32'(cfg.sample_air)) begin
                  nxt.air = 1'b0; nxt.sub = 3'd3; nxt.started = 1'b0;
                end
              end
              3'd3: begin
                nxt.ph_smp = ph_reading; nxt.temp = temp_reading; nxt.kh = kc;
                if (kbad) begin
                  nxt.err = tps_pkg::E_KH; nxt.valid = 1'b0;
                end else if (ad < 12'd10 || ad > 12'd400) begin
                  nxt.err = tps_pkg::E_DELTA; nxt.valid = 1'b0;
                end else begin
                  nxt.err = tps_pkg::E_NONE; nxt.valid = 1'b1;
                end
                nxt.sub = 3'd4; nxt.started = 1'b0;
              end
              3'd4: begin
                nxt.pb = tps_pkg::P_OFF; nxt.air = 1'b0;
                nxt.sub = 3'd0; nxt.started = 1'b0;
                nxt.phase = tps_pkg::PH_FIN; adv = 1'b1;
              end
              default: begin nxt.sub = 3'd0; nxt.started = 1'b0; end
            endcase
          end
          tps_pkg::PH_FIN: begin
            nxt.pa = tps_pkg::P_OFF; nxt.pb = tps_pkg::P_OFF;
            nxt.pc = tps_pkg::P_OFF; nxt.air = 1'b0;
            nxt.phase = tps_pkg::PH_DONE; adv = 1'b1;
          end
          tps_pkg::PH_DONE: nxt.phase = tps_pkg::PH_IDLE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
